/* design/dpa_pkg.sv */
`default_nettype none

package dpa_pkg;

	// Item and pile store geometry.
	localparam int DATA_W    = 32;
	localparam int MAX_PILES = 1024;
	localparam int CNT_W     = $clog2(MAX_PILES + 1);

	// Result field widths on the output stream.
	localparam int OUT_W   = 11;
	localparam int MDATA_W = ((2 * OUT_W + 1 + 7) / 8) * 8;

	// Configuration register file.
	localparam int LIMIT_W = 11;
	localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

	// Register index decoded from paddr above the byte offset.
	localparam logic [PADDR_W-3:0] REG_PILE_LIMIT = '0;

	// One request as it travels down the row of pile cells.
	typedef struct packed {
		logic                     valid;
		logic                     start;
		logic                     done;
		logic signed [DATA_W-1:0] value;
		logic [CNT_W-1:0]         pile;
		logic [CNT_W-1:0]         cnt;
	} item_t;

endpackage

`default_nettype wire

/* design/decreasing_pile_assigner_top.sv */
// Decreasing pile assigner.
// Requests arrive on the s_ stream: s_tdata carries a signed 32-bit value and
// s_tuser flags the first value of a sequence, which clears all piles and the
// failure flag before the value is placed. Each request gives one result on
// the m_ stream: the pile it landed on (0 if the store was full), the number
// of open piles and a sticky failure flag.
// The piles sit in a row of 1024 cells. A request enters an input register,
// then moves one cell per cycle while the row advances; each cell compares the
// value with its own top and either takes it or passes it on. A final stage
// applies pile_limit and keeps the failure flag. A new request may enter
// every cycle while the result register is free or being taken, so
// throughput is one request per cycle.
// While a result waits with m_tready low the whole row holds; the input
// register still takes one more request if it is empty. pile_limit is written
// over the APB port at byte address 0 and should only change while no
// request is in flight.
// Reset empties every pile, clears the failure flag and sets the limit to
// 1024.
`default_nettype none

module decreasing_pile_assigner_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,   // [31:0] value
	input  logic                        s_tuser,   // [0] starts_sequence
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [dpa_pkg::MDATA_W-1:0] m_tdata,   // [10:0] pile_index,
	                                               // [21:11] piles_in_use, [22] failed
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dpa_pkg::PADDR_W-1:0] paddr,
	input  logic [dpa_pkg::PDATA_W-1:0] pwdata,
	output logic [dpa_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import dpa_pkg::*;

	logic [LIMIT_W-1:0] pile_limit;
	logic               adv;
	item_t              s0_q;
	item_t              chain [0:MAX_PILES];
	item_t              last;
	logic               over;
	logic               fail_nxt;
	logic               fail_seen_q;
	logic               res_v_q;
	logic [OUT_W-1:0]   res_pile_q;
	logic [OUT_W-1:0]   res_cnt_q;
	logic               res_fail_q;

	dpa_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.pile_limit (pile_limit)
	);

	// The row moves when the result register is free or being taken.
	assign adv      = !res_v_q || m_tready;
	assign s_tready = !s0_q.valid || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_q <= '0;
		end else if (s_tready) begin
			s0_q.valid <= s_tvalid;
			s0_q.start <= s_tuser;
			s0_q.done  <= 1'b0;
			s0_q.value <= s_tdata;
			s0_q.pile  <= '0;
			s0_q.cnt   <= '0;
		end
	end

	assign chain[0] = s0_q;

	// Row of pile cells.
	for (genvar i = 0; i < MAX_PILES; i++) begin : g_cell
		dpa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.pile_no  (CNT_W'(i + 1)),
			.item_in  (chain[i]),
			.item_out (chain[i+1])
		);
	end

	assign last = chain[MAX_PILES];

	// A request that leaves the row unplaced found the store full.
	assign over     = !last.done;
	assign fail_nxt = (!last.start && fail_seen_q) || over ||
		(CMP_W'(last.cnt) > CMP_W'(pile_limit));

	// Result register and sticky failure flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q     <= 1'b0;
			fail_seen_q <= 1'b0;
		end else if (adv) begin
			res_v_q <= last.valid;
			if (last.valid) begin
				fail_seen_q <= fail_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last.valid) begin
			res_pile_q <= OUT_W'(last.pile);
			res_cnt_q  <= OUT_W'(last.cnt);
			res_fail_q <= fail_nxt;
		end
	end

	assign m_tvalid = res_v_q;
	assign m_tdata  = MDATA_W'({res_fail_q, res_cnt_q, res_pile_q});

endmodule

`default_nettype wire

/* design/dpa_regs.sv */
`default_nettype none

module dpa_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dpa_pkg::PADDR_W-1:0] paddr,
	input  logic [dpa_pkg::PDATA_W-1:0] pwdata,
	output logic [dpa_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output logic [dpa_pkg::LIMIT_W-1:0] pile_limit
);
	import dpa_pkg::*;

	logic                 sel_limit;
	logic [LIMIT_W-1:0]   pile_limit_q;

	assign pready    = 1'b1;
	assign sel_limit = (paddr[PADDR_W-1:2] == REG_PILE_LIMIT);

	// The limit register is written in the access phase of a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pile_limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && sel_limit) begin
			pile_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// Read back; unmapped addresses read as zero.
	always_comb begin
		prdata = '0;
		if (sel_limit) begin
			prdata = PDATA_W'(pile_limit_q);
		end
	end

	assign pile_limit = pile_limit_q;

endmodule

`default_nettype wire

/* design/dpa_cell.sv */
`default_nettype none

module dpa_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic [dpa_pkg::CNT_W-1:0] pile_no,
	input  dpa_pkg::item_t            item_in,
	output dpa_pkg::item_t            item_out
);
	import dpa_pkg::*;

	logic signed [DATA_W-1:0] top_q;
	logic                     open_q;
	logic                     open_eff;
	logic                     hit;
	item_t                    nxt;
	item_t                    item_q;

	// A request with a sequence start sees this pile as closed.
	assign open_eff = open_q && !item_in.start;

	// Place here if the pile is free, or its top is not above the value.
	assign hit = item_in.valid && !item_in.done &&
		(!open_eff || (top_q <= item_in.value));

	// Mark the request placed and count this pile if it is open afterwards.
	always_comb begin
		nxt = item_in;
		if (hit) begin
			nxt.done = 1'b1;
			nxt.pile = pile_no;
		end
		if (open_eff || hit) begin
			nxt.cnt = item_in.cnt + CNT_W'(1);
		end
	end

	// Pile top; only read once the pile has been opened.
	always_ff @(posedge clk) begin
		if (adv && hit) begin
			top_q <= item_in.value;
		end
	end

	// Pile open flag and the hand-off register to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			item_q <= '0;
		end else if (adv) begin
			if (item_in.valid) begin
				open_q <= open_eff || hit;
			end
			item_q <= nxt;
		end
	end

	assign item_out = item_q;

endmodule

`default_nettype wire

/* design/dpa_checker.sv */
`default_nettype none

module dpa_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [dpa_pkg::MDATA_W-1:0] m_tdata,
	input  logic                        psel,
	input  logic                        pready
);
	import dpa_pkg::*;

	logic [OUT_W-1:0] pile_index;
	logic [OUT_W-1:0] piles_in_use;
	logic             failed;

	assign pile_index   = m_tdata[OUT_W-1:0];
	assign piles_in_use = m_tdata[2*OUT_W-1:OUT_W];
	assign failed       = m_tdata[2*OUT_W];

	// A placed value lands on one of the piles that are open.
	a_pile_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (pile_index != '0) |-> (pile_index <= piles_in_use))
		else $error("pile index beyond open piles");

	// A dropped value means the store is full and the sequence has failed.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (pile_index == '0) |->
			failed && (piles_in_use == OUT_W'(MAX_PILES)))
		else $error("value dropped without a full store");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The configuration port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("pready low during a transfer");

endmodule

bind decreasing_pile_assigner_top dpa_checker u_dpa_checker (.*);

`default_nettype wire
